// ----- hw/rtl/image_mse_similarity_unit_macros.svh -----
// assertion macros for the image mse similarity unit
// expects i_clk and i_rst_n in the module that includes it
`ifndef IMAGE_MSE_SIMILARITY_UNIT_MACROS_SVH
`define IMAGE_MSE_SIMILARITY_UNIT_MACROS_SVH

// same-cycle implication, disabled in reset
`define IMSE_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define IMSE_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/imse_pkg.sv -----
// shared constants and types of the image mse similarity unit
// no dependencies
`timescale 1ns / 1ps

package imse_pkg;

    localparam int MAX_PIXELS = 4194304;

    localparam int PIX_W      = 8;
    localparam int SQ_W       = 2 * PIX_W;
    localparam int CNT_W      = $clog2(MAX_PIXELS + 1);
    localparam int SUM_W      = CNT_W + SQ_W;
    localparam int FULL_SCALE = 65025;
    localparam int DEN_W      = CNT_W + 16;
    localparam int FRAC_W     = 16;
    localparam int PCT_SCALE  = 100;
    localparam int PCT_LOG    = $clog2(PCT_SCALE);
    localparam int N100_W     = DEN_W + PCT_LOG;

    localparam int MSE_W      = 32;
    localparam int SIM_W      = 23;
    localparam int SEEN_W     = 23;

    localparam int MSE_STEPS  = MSE_W;
    localparam int SIM_STEPS  = SIM_W;
    localparam int STEP_W     = $clog2(MSE_STEPS);

    typedef struct packed {
        logic acc;
        logic mse_ld;
        logic sim_ld;
        logic div_step;
        logic out_load;
    } t_cmd;

endpackage

// ----- hw/rtl/imse_if.sv -----
// request channels of the image mse similarity unit: pixel pairs in, results out
// depends on imse_pkg
`timescale 1ns / 1ps

interface imse_pix_if;
    import imse_pkg::*;

    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_a;
    logic [PIX_W-1:0] pixel_b;
    logic             last_pixel;

    modport source (output valid, output pixel_a, output pixel_b, output last_pixel,
                    input ready);
    modport sink   (input valid, input pixel_a, input pixel_b, input last_pixel,
                    output ready);
endinterface

interface imse_res_if;
    import imse_pkg::*;

    logic              valid;
    logic              ready;
    logic [MSE_W-1:0]  mean_sq_error;
    logic [SIM_W-1:0]  similarity_pct;
    logic [SEEN_W-1:0] pixels_seen;
    logic              count_overflow;

    modport source (output valid, output mean_sq_error, output similarity_pct,
                    output pixels_seen, output count_overflow, input ready);
    modport sink   (input valid, input mean_sq_error, input similarity_pct,
                    input pixels_seen, input count_overflow, output ready);
endinterface

// ----- hw/rtl/imse_ctrl.sv -----
// controller: accumulate phase, shared divider sequencing, result hand-off
// depends on imse_pkg and the assertion macro header
`timescale 1ns / 1ps

module imse_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    input  logic          i_out_ready,
    output logic          o_in_ready,
    output logic          o_out_valid,
    output imse_pkg::t_cmd o_cmd
);
    import imse_pkg::*;

    typedef enum logic [5:0] {
        S_ACC     = 6'b000001,
        S_MSE_LD  = 6'b000010,
        S_MSE_RUN = 6'b000100,
        S_SIM_LD  = 6'b001000,
        S_SIM_RUN = 6'b010000,
        S_DONE    = 6'b100000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_out_vld, n_out_vld;
    t_cmd              cmd;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        cmd     = '0;
        unique case (r_state)
            S_ACC: begin
                cmd.acc = i_in_valid;
                if (i_in_valid && i_in_last) begin
                    n_state = S_MSE_LD;
                end
            end
            S_MSE_LD: begin
                cmd.mse_ld = 1'b1;
                n_step     = STEP_W'(MSE_STEPS - 1);
                n_state    = S_MSE_RUN;
            end
            S_MSE_RUN: begin
                cmd.div_step = 1'b1;
                if (r_step == '0) begin
                    n_state = S_SIM_LD;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_SIM_LD: begin
                cmd.sim_ld = 1'b1;
                n_step     = STEP_W'(SIM_STEPS - 1);
                n_state    = S_SIM_RUN;
            end
            S_SIM_RUN: begin
                cmd.div_step = 1'b1;
                if (r_step == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_vld || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_comb begin
        if (cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_ACC;
            r_step    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_ACC);
    assign o_out_valid = r_out_vld;
    assign o_cmd       = cmd;

    `include "image_mse_similarity_unit_macros.svh"

    `IMSE_ASSERT_NXT(a_last_starts_div, i_in_valid && o_in_ready && i_in_last,
        r_state == S_MSE_LD, "last request did not start the division")
    `IMSE_ASSERT_NXT(a_load_shows_result, cmd.out_load, r_out_vld,
        "result load did not raise output valid")
    `IMSE_ASSERT_IMP(a_no_accept_in_div, cmd.div_step, !o_in_ready,
        "input open while the divider runs")

endmodule

// ----- hw/rtl/imse_dpath.sv -----
// datapath: squared-difference accumulator, shared restoring divider, result register
// depends on imse_pkg and the assertion macro header
`timescale 1ns / 1ps

module imse_dpath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  imse_pkg::t_cmd              i_cmd,
    input  logic [imse_pkg::PIX_W-1:0]  i_pixel_a,
    input  logic [imse_pkg::PIX_W-1:0]  i_pixel_b,
    output logic [imse_pkg::MSE_W-1:0]  o_mean_sq_error,
    output logic [imse_pkg::SIM_W-1:0]  o_similarity_pct,
    output logic [imse_pkg::SEEN_W-1:0] o_pixels_seen,
    output logic                        o_count_overflow
);
    import imse_pkg::*;

    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_ovf;

    logic [PIX_W-1:0]  diff;
    logic [SQ_W-1:0]   sq;
    logic              cnt_full;

    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_num;
    logic [N100_W-1:0] r_n100;

    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_dvs;
    logic [MSE_W-1:0]  r_low;
    logic [MSE_W-1:0]  r_quo;
    logic [MSE_W-1:0]  r_mse;

    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    trial_sub;
    logic              fits;
    logic [DEN_W-1:0]  n_rem;

    logic [MSE_W-1:0]  r_o_mse;
    logic [SIM_W-1:0]  r_o_sim;
    logic [SEEN_W-1:0] r_o_seen;
    logic              r_o_ovf;

    assign diff     = (i_pixel_a >= i_pixel_b) ? (i_pixel_a - i_pixel_b)
                                               : (i_pixel_b - i_pixel_a);
    assign sq       = SQ_W'(diff) * SQ_W'(diff);
    assign cnt_full = (r_cnt >= CNT_W'(MAX_PIXELS));

    // accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_sum <= '0;
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else if (i_cmd.acc) begin
            if (cnt_full) begin
                r_ovf <= 1'b1;
            end else begin
                r_sum <= r_sum + SUM_W'(sq);
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // similarity operands, settled long before the second division starts
    always_ff @(posedge i_clk) begin
        r_den  <= DEN_W'(r_cnt) * DEN_W'(FULL_SCALE);
        r_num  <= (r_den >= DEN_W'(r_sum)) ? (r_den - DEN_W'(r_sum)) : '0;
        r_n100 <= N100_W'(r_num) * N100_W'(PCT_SCALE);
    end

    // one quotient bit per cycle
    assign trial     = {r_rem, r_low[MSE_W-1]};
    assign trial_sub = trial - {1'b0, r_dvs};
    assign fits      = (trial >= {1'b0, r_dvs});
    assign n_rem     = fits ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mse_ld) begin
            r_rem <= DEN_W'(r_sum[SUM_W-1:FRAC_W]);
            r_low <= {r_sum[FRAC_W-1:0], {(MSE_W-FRAC_W){1'b0}}};
            r_dvs <= DEN_W'(r_cnt);
            r_quo <= '0;
        end else if (i_cmd.sim_ld) begin
            r_rem <= r_n100[N100_W-1:PCT_LOG];
            r_low <= {r_n100[PCT_LOG-1:0], {(MSE_W-PCT_LOG){1'b0}}};
            r_dvs <= r_den;
            r_quo <= '0;
            r_mse <= r_quo;
        end else if (i_cmd.div_step) begin
            r_rem <= n_rem;
            r_low <= {r_low[MSE_W-2:0], 1'b0};
            r_quo <= {r_quo[MSE_W-2:0], fits};
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_mse  <= r_mse;
            r_o_sim  <= r_quo[SIM_W-1:0];
            r_o_seen <= SEEN_W'(r_cnt);
            r_o_ovf  <= r_ovf;
        end
    end

    assign o_mean_sq_error  = r_o_mse;
    assign o_similarity_pct = r_o_sim;
    assign o_pixels_seen    = r_o_seen;
    assign o_count_overflow = r_o_ovf;

    `include "image_mse_similarity_unit_macros.svh"

    `IMSE_ASSERT_IMP(a_rem_below_dvs, i_cmd.div_step, r_rem < r_dvs,
        "divider partial remainder not below divisor")
    `IMSE_ASSERT_IMP(a_cnt_bounded, 1'b1, r_cnt <= CNT_W'(MAX_PIXELS),
        "pair count beyond its limit")
    `IMSE_ASSERT_NXT(a_full_sets_ovf, i_cmd.acc && cnt_full, r_ovf,
        "request on a full count did not flag overflow")

endmodule

// ----- hw/rtl/image_mse_similarity_unit.sv -----
// top level of the image mse similarity unit
// depends on imse_pkg, imse_if, imse_ctrl and imse_dpath
`timescale 1ns / 1ps

// Pixel pairs are taken one per cycle while an image is being accumulated.
// After the pair marked last, one shared radix-2 restoring divider first
// produces the Q16 mean squared error (32 steps) and then the Q16 similarity
// percentage (23 steps); the result is offered once both are done, and no pair
// is taken in between. The result sits in an output register, so the next
// image is accepted while it waits to be collected. The pair count saturates
// at MAX_PIXELS, further pairs only set the overflow flag, and all accumulator
// state clears when the result is registered.

module image_mse_similarity_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    imse_pix_if.sink     i_pix,
    imse_res_if.source   o_res
);
    import imse_pkg::*;

    t_cmd cmd;

    imse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_pix.valid),
        .i_in_last   (i_pix.last_pixel),
        .i_out_ready (o_res.ready),
        .o_in_ready  (i_pix.ready),
        .o_out_valid (o_res.valid),
        .o_cmd       (cmd)
    );

    imse_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_pixel_a        (i_pix.pixel_a),
        .i_pixel_b        (i_pix.pixel_b),
        .o_mean_sq_error  (o_res.mean_sq_error),
        .o_similarity_pct (o_res.similarity_pct),
        .o_pixels_seen    (o_res.pixels_seen),
        .o_count_overflow (o_res.count_overflow)
    );

endmodule

// ----- bench/tb_image_mse_similarity_unit.sv -----
// self-checking testbench of the image mse similarity unit: pixel-pair requests in,
// per-image error and similarity results out, checked against an in-bench score model
// depends on imse_pkg, imse_if and the image_mse_similarity_unit rtl
`timescale 1ns / 1ps

module tb_image_mse_similarity_unit;
    import imse_pkg::*;

    localparam int ITEM_TARGET    = 950;
    localparam int TAIL_PAIRS     = 120;
    localparam int FULL_RUN       = 40;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int HOLD_OFF       = 400;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [MSE_W-1:0]  mse;
        logic [SIM_W-1:0]  sim;
        logic [SEEN_W-1:0] seen;
        logic              ovf;
    } t_score;

    logic clk = 1'b0;
    logic rst_n;

    imse_pix_if pix ();
    imse_res_if res ();

    image_mse_similarity_unit u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix),
        .o_res   (res)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // running image state of the score model
    logic [SUM_W-1:0] sq_sum;
    logic [CNT_W-1:0] pair_cnt;
    logic             ovf_seen;
    t_score           expected_scores[$];

    int unsigned pairs_sent;
    int unsigned images_checked;
    int unsigned saturated_images;
    int unsigned mismatches;
    int unsigned idle_cycles;
    int unsigned sink_hold;
    int unsigned hold_request;
    bit          pace_sender;
    bit          stall_sink;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 15);
        else
            return $urandom_range(30, 80);
    endfunction

    function automatic void absorb_pair(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b, logic last);
        logic [PIX_W-1:0] diff;
        logic [63:0]      den;
        logic [63:0]      num;
        t_score           s;
        diff = (a >= b) ? a - b : b - a;
        if (pair_cnt < MAX_PIXELS) begin
            sq_sum   = sq_sum + SUM_W'(64'(diff) * 64'(diff));
            pair_cnt = pair_cnt + 1'b1;
        end else begin
            ovf_seen = 1'b1;
        end
        if (last) begin
            den    = 64'(FULL_SCALE) * 64'(pair_cnt);
            num    = (den >= 64'(sq_sum)) ? den - 64'(sq_sum) : 64'd0;
            s.mse  = MSE_W'((64'(sq_sum) << FRAC_W) / 64'(pair_cnt));
            s.sim  = SIM_W'((num * (64'(PCT_SCALE) << FRAC_W)) / den);
            s.seen = SEEN_W'(pair_cnt);
            s.ovf  = ovf_seen;
            expected_scores.push_back(s);
            sq_sum   = '0;
            pair_cnt = '0;
            ovf_seen = 1'b0;
        end
    endfunction

    task automatic send_pair(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                             input logic last);
        int unsigned gap;
        gap = pace_sender ? pick_gap() : 0;
        if (gap != 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix.valid      <= 1'b1;
        pix.pixel_a    <= a;
        pix.pixel_b    <= b;
        pix.last_pixel <= last;
        @(posedge clk);
        while (!pix.ready) @(posedge clk);
        pairs_sent++;
        absorb_pair(a, b, last);
    endtask

    task automatic test_extremes();
        pace_sender = 1'b1;
        stall_sink  = 1'b1;
        send_pair(8'd0,   8'd0,   1'b1);
        send_pair(8'd255, 8'd0,   1'b1);
        send_pair(8'd0,   8'd255, 1'b1);
        send_pair(8'd255, 8'd255, 1'b1);
        send_pair(8'd1,   8'd0,   1'b1);
        send_pair(8'd128, 8'd127, 1'b1);
        send_pair(8'd0,   8'd255, 1'b0);
        send_pair(8'd255, 8'd255, 1'b1);
        send_pair(8'hAA,  8'h55,  1'b0);
        send_pair(8'h55,  8'hAA,  1'b0);
        send_pair(8'hFF,  8'h00,  1'b0);
        send_pair(8'h00,  8'h00,  1'b1);
    endtask

    task automatic send_image(input int unsigned pairs, input int unsigned flavour);
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        int               t;
        for (int unsigned i = 0; i < pairs; i++) begin
            a = PIX_W'($urandom_range(0, 255));
            case (flavour)
                0: b = PIX_W'($urandom_range(0, 255));
                1: b = a;
                2: begin
                    t = int'(a) + $urandom_range(0, 8) - 4;
                    b = (t < 0) ? 8'd0 : (t > 255) ? 8'd255 : t[PIX_W-1:0];
                end
                default: begin
                    a = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                end
            endcase
            send_pair(a, b, i == pairs - 1);
        end
    endtask

    task automatic test_random_images();
        int unsigned r;
        int unsigned pairs;
        while (pairs_sent < ITEM_TARGET - TAIL_PAIRS) begin
            r = $urandom_range(0, 99);
            if (r < 70)
                pairs = $urandom_range(1, 8);
            else if (r < 95)
                pairs = $urandom_range(9, 40);
            else
                pairs = $urandom_range(60, 200);
            pace_sender = ($urandom_range(0, 3) != 0);
            stall_sink  = ($urandom_range(0, 3) != 0);
            send_image(pairs, $urandom_range(0, 3));
        end
    endtask

    // receiver stops collecting while several images queue up behind it
    task automatic test_backpressure();
        pace_sender  = 1'b0;
        stall_sink   = 1'b0;
        hold_request = HOLD_OFF;
        repeat (5) send_image($urandom_range(3, 20), $urandom_range(0, 3));
    endtask

    // a long image of full-scale differences, then a small image to show the clear
    task automatic test_full_scale_clear();
        pace_sender = 1'b0;
        stall_sink  = 1'b1;
        for (int unsigned i = 0; i < FULL_RUN; i++)
            send_pair(8'd255, 8'd0, 1'b0);
        send_pair(8'd0, 8'd255, 1'b1);
        pace_sender = 1'b1;
        send_image(3, 0);
    endtask

    initial begin
        res.ready <= 1'b0;
        sink_hold  = 0;
        forever begin
            @(posedge clk);
            if (hold_request != 0) begin
                sink_hold    = hold_request;
                hold_request = 0;
            end else if (sink_hold == 0 && stall_sink) begin
                sink_hold = pick_gap();
            end
            if (sink_hold != 0) begin
                res.ready <= 1'b0;
                sink_hold--;
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : check_results
        t_score got;
        t_score exp_s;
        if (rst_n && res.valid && res.ready) begin
            got = '{res.mean_sq_error, res.similarity_pct, res.pixels_seen,
                    res.count_overflow};
            if (expected_scores.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result: mse %0d sim %0d seen %0d ovf %0b",
                             got.mse, got.sim, got.seen, got.ovf);
            end else begin
                exp_s = expected_scores.pop_front();
                images_checked++;
                if (exp_s.ovf)
                    saturated_images++;
                if (got !== exp_s) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display({"image %0d: exp mse %0d sim %0d seen %0d ovf %0b,",
                                  " got mse %0d sim %0d seen %0d ovf %0b"},
                                 images_checked, exp_s.mse, exp_s.sim, exp_s.seen,
                                 exp_s.ovf, got.mse, got.sim, got.seen, got.ovf);
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((pix.valid && pix.ready) || (res.valid && res.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        rst_n            = 1'b0;
        pix.valid       <= 1'b0;
        pix.pixel_a     <= '0;
        pix.pixel_b     <= '0;
        pix.last_pixel  <= 1'b0;
        sq_sum           = '0;
        pair_cnt         = '0;
        ovf_seen         = 1'b0;
        pairs_sent       = 0;
        images_checked   = 0;
        saturated_images = 0;
        mismatches       = 0;
        idle_cycles      = 0;
        hold_request     = 0;
        pace_sender      = 1'b0;
        stall_sink       = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_extremes();
        test_random_images();
        test_backpressure();
        test_full_scale_clear();
        pix.valid <= 1'b0;

        while (expected_scores.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d images from %0d pixel pairs, %0d flagged overflow",
                 images_checked, pairs_sent, saturated_images);
        $display("included a %0d-cycle receiver hold-off; %0d mismatching results",
                 HOLD_OFF, mismatches);
        if (mismatches == 0 && expected_scores.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
